// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define WBRP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define WBRP_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define WBRP_ASSERT(name, prop, msg)
`define WBRP_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

// ===== hw/rtl/wbrp_pkg.sv =====
`timescale 1ns / 1ps

package wbrp_pkg;

  localparam int unsigned HdrLen = 12;
  localparam int unsigned SeqLen = 8;

  localparam logic [1:0] KindKey    = 2'd0;
  localparam logic [1:0] KindValue  = 2'd1;
  localparam logic [1:0] KindDone   = 2'd2;
  localparam logic [1:0] KindStatus = 2'd3;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StTooSmall = 3'd1;
  localparam logic [2:0] StBadPut   = 3'd2;
  localparam logic [2:0] StBadDel   = 3'd3;
  localparam logic [2:0] StBadTag   = 3'd4;
  localparam logic [2:0] StBadCount = 3'd5;

  localparam logic CfgPointerMode = 1'b0;
  localparam logic CfgFileNumber  = 1'b1;

  typedef struct packed {
    logic [7:0]  in_byte;
    logic        batch_first;
    logic        batch_last;
    logic [31:0] start_position;
  } wbrp_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  data_byte;
    logic        field_end;
    logic        is_delete;
    logic [63:0] record_sequence;
    logic [31:0] log_position;
    logic [31:0] pointer_file;
    logic [2:0]  status_code;
    logic        run_last;
  } wbrp_out_t;

endpackage

// ===== hw/rtl/write_batch_record_parser.sv =====
`timescale 1ns / 1ps
// Write batch parser: takes a serialized batch one byte per input word and
// returns key bytes, value bytes (not in pointer mode), one done word per record
// and one status word at the last byte of the batch.
// Input channel: in_valid_i/in_ready_o with in_data_i; batch_first restarts
// parsing and samples start_position, batch_last closes the batch.
// Output channel: out_valid_o/out_ready_i with out_data_o; run_last marks the
// last result word caused by one input word.
// Config channel: cfg_valid_i/cfg_ready_o, index 0 pointer mode, 1 file number;
// always ready; the user must write only while the block is idle (unchecked).
// The first result word is valid in the cycle after the input word is taken.
// Throughput: one input word per cycle while each word yields at most one
// result and the receiver takes it; a word that yields two or three results
// occupies the three-entry result buffer, so the next input waits until at
// most one of them is left and being taken.
// A stalled receiver holds the buffer; input is refused until it drains.
// Reset clears the parser to the start of a header at offset zero and empties
// the result buffer; configuration resets to zero.
module write_batch_record_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wbrp_pkg::wbrp_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wbrp_pkg::wbrp_out_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import wbrp_pkg::*;

`include "assert_macros.svh"

  typedef enum logic [2:0] {
    PhHeader, PhTag, PhKeyLen, PhKey, PhValLen, PhVal, PhError, PhIdle
  } phase_e;

  phase_e      phase_q, phase_d, ph_e;
  logic [3:0]  hdr_idx_q, hdr_idx_d, idx_e;
  logic [63:0] hdr_seq_q, hdr_seq_d, seq_e;
  logic [31:0] hdr_cnt_q, hdr_cnt_d, cnt_e;
  logic [31:0] seen_q, seen_d, seen_e;
  logic [31:0] vint_q, vint_d, vint_e, vint_new;
  logic [2:0]  vbytes_q, vbytes_d, vbytes_e, vbytes_new;
  logic [31:0] remain_q, remain_d, remain_e, remain_dec;
  logic        del_q, del_d, del_e;
  logic [31:0] run_pos_q, run_pos_d;
  logic [31:0] rec_start_q, rec_start_d, rstart_e;
  logic [2:0]  err_q, err_d, err_e;
  logic        vp_mode_q;
  logic [31:0] file_num_q;

  logic        in_fire, out_fire, active, upd;
  logic [7:0]  b;
  logic [38:0] vshift;
  logic        emit_data, emit_done, emit_status, do_finish, do_after_key;
  wbrp_out_t   res_data, res_done, res_status;
  wbrp_out_t   res_q [3];
  wbrp_out_t   slot0, slot1;
  logic [1:0]  out_cnt_q, n_res;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (out_cnt_q == 2'd0) || ((out_cnt_q == 2'd1) && out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (out_cnt_q != 2'd0);
  assign out_fire    = out_valid_o && out_ready_i;
  assign out_data_o  = res_q[0];
  assign b           = in_data_i.in_byte;
  assign active      = in_data_i.batch_first || (phase_q != PhIdle);
  assign upd         = in_fire && active;

  always_comb begin
    if (in_data_i.batch_first) begin
      ph_e = PhHeader;  idx_e = '0;  seq_e = '0;  cnt_e = '0;  seen_e = '0;
      vint_e = '0;  vbytes_e = '0;  remain_e = '0;  del_e = 1'b0;  err_e = StOk;
      rstart_e = in_data_i.start_position;
      run_pos_d = in_data_i.start_position + 32'd1;
    end else begin
      ph_e = phase_q;  idx_e = hdr_idx_q;  seq_e = hdr_seq_q;  cnt_e = hdr_cnt_q;
      seen_e = seen_q;  vint_e = vint_q;  vbytes_e = vbytes_q;  remain_e = remain_q;
      del_e = del_q;  err_e = err_q;  rstart_e = rec_start_q;
      run_pos_d = run_pos_q + 32'd1;
    end

    phase_d = ph_e;  hdr_idx_d = idx_e;  hdr_seq_d = seq_e;  hdr_cnt_d = cnt_e;
    seen_d = seen_e;  vint_d = vint_e;  vbytes_d = vbytes_e;  remain_d = remain_e;
    del_d = del_e;  err_d = err_e;  rec_start_d = rstart_e;

    vshift     = {32'd0, b[6:0]} << ({3'd0, vbytes_e} * 6'd7);
    vint_new   = vint_e | vshift[31:0];
    vbytes_new = vbytes_e + 3'd1;
    remain_dec = remain_e - 32'd1;

    emit_data = 1'b0;  do_finish = 1'b0;  do_after_key = 1'b0;
    res_data = '0;
    res_data.data_byte = b;
    res_data.is_delete = del_e;
    res_data.field_end = (remain_e == 32'd1);

    case (ph_e)
      PhHeader: begin
        if (idx_e < 4'(SeqLen)) begin
          hdr_seq_d[{idx_e[2:0], 3'b000} +: 8] = seq_e[{idx_e[2:0], 3'b000} +: 8] | b;
        end else begin
          hdr_cnt_d[{idx_e[1:0], 3'b000} +: 8] = cnt_e[{idx_e[1:0], 3'b000} +: 8] | b;
        end
        hdr_idx_d = idx_e + 4'd1;
        if (hdr_idx_d >= 4'(HdrLen)) begin
          phase_d     = PhTag;
          rec_start_d = run_pos_d;
        end
      end
      PhTag: begin
        if (b == 8'd1 || b == 8'd0) begin
          del_d    = (b == 8'd0);
          vint_d   = '0;
          vbytes_d = '0;
          phase_d  = PhKeyLen;
        end else begin
          err_d   = StBadTag;
          phase_d = PhError;
        end
      end
      PhKeyLen, PhValLen: begin
        vint_d   = vint_new;
        vbytes_d = vbytes_new;
        if (b[7]) begin
          if (vbytes_new >= 3'd5) begin
            err_d   = del_e ? StBadDel : StBadPut;
            phase_d = PhError;
          end
        end else begin
          remain_d = vint_new;
          if (ph_e == PhKeyLen) begin
            if (vint_new == 32'd0) do_after_key = 1'b1;
            else phase_d = PhKey;
          end else begin
            if (vint_new == 32'd0) do_finish = 1'b1;
            else phase_d = PhVal;
          end
        end
      end
      PhKey: begin
        emit_data = 1'b1;
        res_data.result_kind = KindKey;
        remain_d = remain_dec;
        if (remain_dec == 32'd0) do_after_key = 1'b1;
      end
      PhVal: begin
        emit_data = !vp_mode_q;
        res_data.result_kind = KindValue;
        remain_d = remain_dec;
        if (remain_dec == 32'd0) do_finish = 1'b1;
      end
      default: ;
    endcase

    if (do_after_key) begin
      if (del_e) begin
        do_finish = 1'b1;
      end else begin
        vint_d   = '0;
        vbytes_d = '0;
        phase_d  = PhValLen;
      end
    end

    emit_done = do_finish;
    res_done  = '0;
    res_done.result_kind     = KindDone;
    res_done.is_delete       = del_e;
    res_done.record_sequence = seq_e + {32'd0, seen_e};
    res_done.log_position    = rstart_e;
    res_done.pointer_file    = (vp_mode_q && !del_e) ? file_num_q : 32'd0;
    if (do_finish) begin
      seen_d      = seen_e + 32'd1;
      rec_start_d = run_pos_d;
      phase_d     = PhTag;
    end

    emit_status = in_data_i.batch_last;
    res_status  = '0;
    res_status.result_kind  = KindStatus;
    res_status.log_position = rec_start_d;
    if (err_d != StOk) res_status.status_code = err_d;
    else if (phase_d == PhHeader) res_status.status_code = StTooSmall;
    else if (phase_d == PhTag) res_status.status_code = (seen_d == hdr_cnt_d) ? StOk : StBadCount;
    else res_status.status_code = del_d ? StBadDel : StBadPut;
    if (in_data_i.batch_last) phase_d = PhIdle;

    res_data.run_last   = !emit_done && !emit_status;
    res_done.run_last   = !emit_status;
    res_status.run_last = 1'b1;

    n_res = {1'b0, emit_data} + {1'b0, emit_done} + {1'b0, emit_status};
    slot0 = emit_data ? res_data : (emit_done ? res_done : res_status);
    slot1 = (emit_data && emit_done) ? res_done : res_status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHeader;
      hdr_idx_q   <= '0;
      hdr_seq_q   <= '0;
      hdr_cnt_q   <= '0;
      seen_q      <= '0;
      vint_q      <= '0;
      vbytes_q    <= '0;
      remain_q    <= '0;
      del_q       <= 1'b0;
      run_pos_q   <= '0;
      rec_start_q <= '0;
      err_q       <= StOk;
      vp_mode_q   <= 1'b0;
      file_num_q  <= '0;
      out_cnt_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgPointerMode: vp_mode_q  <= cfg_data_i[0];
          CfgFileNumber:  file_num_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (upd) begin
        phase_q     <= phase_d;
        hdr_idx_q   <= hdr_idx_d;
        hdr_seq_q   <= hdr_seq_d;
        hdr_cnt_q   <= hdr_cnt_d;
        seen_q      <= seen_d;
        vint_q      <= vint_d;
        vbytes_q    <= vbytes_d;
        remain_q    <= remain_d;
        del_q       <= del_d;
        run_pos_q   <= run_pos_d;
        rec_start_q <= rec_start_d;
        err_q       <= err_d;
      end
      if (upd) begin
        out_cnt_q <= n_res;
      end else if (in_fire || out_fire) begin
        out_cnt_q <= out_fire ? out_cnt_q - 2'd1 : out_cnt_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      res_q[0] <= slot0;
      res_q[1] <= slot1;
      res_q[2] <= res_status;
    end else if (out_fire) begin
      res_q[0] <= res_q[1];
      res_q[1] <= res_q[2];
    end
  end

  `WBRP_ASSERT(a_status_ends_run,
      (out_valid_o && out_data_o.result_kind == KindStatus) |-> out_data_o.run_last,
      "status word without run_last")
  `WBRP_ASSERT(a_run_last_drains,
      (out_valid_o && out_data_o.run_last) |-> (out_cnt_q == 2'd1),
      "run_last word is not the last buffered word")
  `WBRP_ASSERT(a_field_nonempty,
      (phase_q == PhKey || phase_q == PhVal) |-> (remain_q != 32'd0),
      "field phase with no bytes remaining")
  `WBRP_ASSERT_NEXT(a_idle_silent,
      in_fire && !in_data_i.batch_first && phase_q == PhIdle,
      out_cnt_q == 2'd0 && phase_q == PhIdle,
      "word after batch end produced results")
  `WBRP_ASSERT_NEXT(a_last_status,
      in_fire && in_data_i.batch_last && active,
      phase_q == PhIdle && out_cnt_q != 2'd0,
      "last byte did not close the batch")

endmodule

// ===== tb/tb_write_batch_record_parser.sv =====
`timescale 1ns / 1ps

module tb_write_batch_record_parser;
  import wbrp_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int MaxPrinted = 100;

  typedef enum logic [2:0] {
    StepHeader, StepTag, StepKeyLen, StepKey, StepValLen, StepVal, StepDiscard, StepDone
  } parse_step_e;

  typedef enum int {
    ModeOk, ModeCount, ModeShort, ModeTag, ModeLongLen, ModeCutPut, ModeCutDel, ModeNoise,
    NumModes
  } batch_mode_e;

  logic        clk = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  wbrp_in_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  wbrp_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CfgPointerMode;
  logic [31:0] cfg_data = '0;

  write_batch_record_parser u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // parser image
  logic        ptr_mode = 1'b0;
  logic [31:0] file_num = '0;
  parse_step_e step_r = StepHeader;
  int          hdr_idx = 0;
  logic [63:0] seq_r = '0;
  logic [31:0] cnt_r = '0;
  logic [31:0] done_cnt = '0;
  logic [31:0] len_r = '0;
  int          len_n = 0;
  logic [31:0] left_r = '0;
  logic        del_r = 1'b0;
  logic [31:0] pos_r = '0;
  logic [31:0] rec_start_r = '0;
  logic [2:0]  err_r = StOk;

  wbrp_out_t   run_words[$];
  wbrp_out_t   parsed_words_q[$];
  logic [7:0]  bytes_q[$];

  int          cycle_cnt = 0;
  int          errors = 0;
  int          n_in_words = 0;
  int          n_out_words = 0;
  int          n_batches = 0;
  bit          pace_on = 1'b1;

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("Timeout after %0d cycles, %0d words still pending", cycle_cnt,
             parsed_words_q.size());
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= MaxPrinted) $display("MISMATCH @%0d: %s", cycle_cnt, msg);
  endtask

  function automatic void add_result(logic [1:0] kind, logic [7:0] data, logic fend,
                                     logic [63:0] seq, logic [31:0] pos, logic [31:0] pf,
                                     logic [2:0] st);
    wbrp_out_t r;
    r = '0;
    r.result_kind     = kind;
    r.data_byte       = data;
    r.field_end       = fend;
    r.is_delete       = (kind == KindStatus) ? 1'b0 : del_r;
    r.record_sequence = seq;
    r.log_position    = pos;
    r.pointer_file    = pf;
    r.status_code     = st;
    run_words.insert(run_words.size(), r);
  endfunction

  function automatic void clear_parse();
    step_r   = StepHeader;
    hdr_idx  = 0;
    seq_r    = '0;
    cnt_r    = '0;
    done_cnt = '0;
    len_r    = '0;
    len_n    = 0;
    left_r   = '0;
    del_r    = 1'b0;
    err_r    = StOk;
  endfunction

  function automatic void start_len(parse_step_e nxt);
    len_r  = '0;
    len_n  = 0;
    step_r = nxt;
  endfunction

  function automatic void close_record();
    logic [31:0] pf;
    pf = (ptr_mode && !del_r) ? file_num : 32'd0;
    add_result(KindDone, 8'd0, 1'b0, seq_r + 64'(done_cnt), rec_start_r, pf, StOk);
    done_cnt    = done_cnt + 1;
    rec_start_r = pos_r;
    step_r      = StepTag;
  endfunction

  function automatic void key_done();
    if (del_r) close_record();
    else start_len(StepValLen);
  endfunction

  task automatic parse_byte(wbrp_in_t w);
    logic [7:0]  b;
    logic [63:0] shifted;
    logic [2:0]  st;
    b = w.in_byte;
    run_words.delete();
    if (w.batch_first) begin
      clear_parse();
      pos_r       = w.start_position;
      rec_start_r = w.start_position;
    end else if (step_r == StepDone) begin
      return;
    end
    pos_r = pos_r + 1;
    case (step_r)
      StepHeader: begin
        if (hdr_idx < SeqLen) seq_r[8*hdr_idx +: 8] = b;
        else if (hdr_idx < HdrLen) cnt_r[8*(hdr_idx-SeqLen) +: 8] = b;
        hdr_idx++;
        if (hdr_idx >= HdrLen) begin
          step_r      = StepTag;
          rec_start_r = pos_r;
        end
      end
      StepTag: begin
        if (b == 8'd1) begin
          del_r = 1'b0;
          start_len(StepKeyLen);
        end else if (b == 8'd0) begin
          del_r = 1'b1;
          start_len(StepKeyLen);
        end else begin
          err_r  = StBadTag;
          step_r = StepDiscard;
        end
      end
      StepKeyLen, StepValLen: begin
        shifted = 64'(b[6:0]) << (7 * len_n);
        len_r   = len_r | shifted[31:0];
        len_n++;
        if (b[7]) begin
          if (len_n >= 5) begin
            err_r  = del_r ? StBadDel : StBadPut;
            step_r = StepDiscard;
          end
        end else begin
          left_r = len_r;
          if (step_r == StepKeyLen) begin
            if (left_r == 0) key_done();
            else step_r = StepKey;
          end else begin
            if (left_r == 0) close_record();
            else step_r = StepVal;
          end
        end
      end
      StepKey: begin
        add_result(KindKey, b, left_r == 1, '0, '0, '0, StOk);
        left_r = left_r - 1;
        if (left_r == 0) key_done();
      end
      StepVal: begin
        if (!ptr_mode) add_result(KindValue, b, left_r == 1, '0, '0, '0, StOk);
        left_r = left_r - 1;
        if (left_r == 0) close_record();
      end
      default: ;
    endcase
    if (w.batch_last) begin
      if (err_r != StOk) st = err_r;
      else if (step_r == StepHeader) st = StTooSmall;
      else if (step_r == StepTag) st = (done_cnt == cnt_r) ? StOk : StBadCount;
      else st = del_r ? StBadDel : StBadPut;
      add_result(KindStatus, 8'd0, 1'b0, '0, rec_start_r, '0, st);
      step_r = StepDone;
    end
    if (run_words.size() > 0) run_words[run_words.size()-1].run_last = 1'b1;
    foreach (run_words[i]) parsed_words_q.insert(parsed_words_q.size(), run_words[i]);
  endtask

  function automatic string field_diffs(wbrp_out_t g, wbrp_out_t e);
    string s;
    s = "";
    if (g.result_kind !== e.result_kind) s = {s, " kind"};
    if (g.data_byte !== e.data_byte) s = {s, " data"};
    if (g.field_end !== e.field_end) s = {s, " field_end"};
    if (g.is_delete !== e.is_delete) s = {s, " is_delete"};
    if (g.record_sequence !== e.record_sequence) s = {s, " sequence"};
    if (g.log_position !== e.log_position) s = {s, " position"};
    if (g.pointer_file !== e.pointer_file) s = {s, " file"};
    if (g.status_code !== e.status_code) s = {s, " status"};
    if (g.run_last !== e.run_last) s = {s, " run_last"};
    return s;
  endfunction

  always @(posedge clk) begin : check_words
    wbrp_out_t want;
    string     diffs;
    if (rst_ni && out_valid && out_ready) begin
      n_out_words++;
      if (parsed_words_q.size() == 0) begin
        report_mismatch($sformatf("word %h with nothing pending", out_data));
      end else begin
        want  = parsed_words_q.pop_front();
        diffs = field_diffs(out_data, want);
        if (diffs != "")
          report_mismatch($sformatf("word %0d:%s got %h exp %h", n_out_words, diffs,
                                    out_data, want));
      end
    end
  end

  initial begin
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      if (pace_on && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end
  end

  task automatic send_batch_byte(wbrp_in_t w);
    if (pace_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_in_words++;
    parse_byte(w);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (parsed_words_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CfgPointerMode) ptr_mode = data[0];
    else file_num = data;
    @(posedge clk);
  endtask

  function automatic void add_byte(logic [7:0] v);
    bytes_q.insert(bytes_q.size(), v);
  endfunction

  task automatic push_header(logic [63:0] seq, logic [31:0] cnt);
    for (int i = 0; i < SeqLen; i++) add_byte(seq[8*i +: 8]);
    for (int i = 0; i < HdrLen - SeqLen; i++) add_byte(cnt[8*i +: 8]);
  endtask

  // small lengths, sometimes padded out to a longer encoding
  task automatic push_len(logic [6:0] len);
    int n;
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 5) : 1;
    if (n == 1) begin
      add_byte({1'b0, len});
    end else begin
      add_byte({1'b1, len});
      repeat (n - 2) add_byte(8'h80);
      add_byte((n == 5) ? {1'b0, 3'($urandom_range(0, 7)), 4'h0} : 8'h00);
    end
  endtask

  task automatic push_record(bit del, int klen, int vlen);
    add_byte(del ? 8'd0 : 8'd1);
    push_len(7'(klen));
    repeat (klen) add_byte(8'($urandom_range(0, 255)));
    if (!del) begin
      push_len(7'(vlen));
      repeat (vlen) add_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic push_random_record();
    int klen;
    klen = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
    push_record(1'($urandom_range(0, 1)), klen, $urandom_range(0, 5));
  endtask

  task automatic push_garbage(int n);
    repeat (n) add_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_bytes(logic [31:0] sp, bit with_first, bit stray_first);
    wbrp_in_t w;
    for (int i = 0; i < bytes_q.size(); i++) begin
      w.in_byte        = bytes_q[i];
      w.batch_first    = (i == 0) ? with_first : (stray_first && $urandom_range(0, 7) == 0);
      w.batch_last     = (i == bytes_q.size() - 1);
      w.start_position = (i == 0) ? sp : $urandom();
      send_batch_byte(w);
    end
    bytes_q.delete();
  endtask

  task automatic send_ignored_byte();
    wbrp_in_t w;
    w.in_byte        = 8'($urandom_range(0, 255));
    w.batch_first    = 1'b0;
    w.batch_last     = 1'($urandom_range(0, 1));
    w.start_position = $urandom();
    send_batch_byte(w);
  endtask

  task automatic send_random_batch(batch_mode_e mode);
    int          nrec;
    int          keep;
    int          rs;
    int          cut;
    bit          del;
    logic [63:0] seq;
    logic [31:0] cnt;
    logic [31:0] sp;
    bytes_q.delete();
    nrec = $urandom_range(0, 3);
    seq  = ($urandom_range(0, 3) == 0) ? 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 2)
                                       : {$urandom(), $urandom()};
    sp   = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFF0 + $urandom_range(0, 15) : $urandom();
    case (mode)
      ModeOk: begin
        push_header(seq, nrec);
        repeat (nrec) push_random_record();
      end
      ModeCount: begin
        cnt = $urandom_range(0, 1) ? $urandom() : nrec + 1;
        if (cnt == nrec) cnt++;
        push_header(seq, cnt);
        repeat (nrec) push_random_record();
      end
      ModeShort: begin
        push_header(seq, $urandom());
        keep = $urandom_range(1, HdrLen - 1);
        while (bytes_q.size() > keep) void'(bytes_q.pop_back());
      end
      ModeTag: begin
        push_header(seq, $urandom_range(0, 3));
        repeat (nrec % 3) push_random_record();
        add_byte(8'($urandom_range(2, 255)));
        push_garbage($urandom_range(0, 3));
      end
      ModeLongLen: begin
        push_header(seq, nrec);
        repeat (nrec % 2) push_random_record();
        del = 1'($urandom_range(0, 1));
        add_byte(del ? 8'd0 : 8'd1);
        if (!del && $urandom_range(0, 1)) begin
          keep = $urandom_range(0, 3);
          push_len(7'(keep));
          push_garbage(keep);
        end
        repeat ($urandom_range(5, 6)) add_byte({1'b1, 7'($urandom_range(0, 127))});
        push_garbage($urandom_range(0, 2));
      end
      ModeCutPut, ModeCutDel: begin
        push_header(seq, nrec + 1);
        repeat (nrec % 3) push_random_record();
        rs = bytes_q.size();
        push_record(mode == ModeCutDel, $urandom_range(0, 4), $urandom_range(1, 4));
        cut = $urandom_range(rs, bytes_q.size() - 2);
        while (bytes_q.size() > cut + 1) void'(bytes_q.pop_back());
      end
      default: begin
        push_garbage($urandom_range(1, 14));
      end
    endcase
    send_bytes(sp, 1'b1, mode == ModeNoise);
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2)) send_ignored_byte();
    n_batches++;
  endtask

  task automatic run_phase(logic ptr, logic [31:0] fnum, int count);
    wait_drained();
    write_reg(CfgPointerMode, {31'($urandom()), ptr});
    write_reg(CfgFileNumber, fnum);
    repeat (count) send_random_batch(batch_mode_e'(n_batches % NumModes));
  endtask

  // batch taken without a leading first flag; sequence wraps on the second record
  task automatic test_implicit_start();
    push_header(64'hFFFF_FFFF_FFFF_FFFF, 32'd2);
    add_byte(8'd0);
    add_byte(8'd1);
    add_byte(8'hFF);
    add_byte(8'd1);
    add_byte(8'd0);
    add_byte(8'd1);
    add_byte(8'h00);
    send_bytes($urandom(), 1'b0, 1'b0);
    n_batches++;
  endtask

  task automatic test_one_byte_batch();
    wbrp_in_t w;
    add_byte(8'h80);
    send_bytes(32'hFFFF_FFFF, 1'b1, 1'b0);
    w.in_byte        = 8'h7F;
    w.batch_first    = 1'b0;
    w.batch_last     = 1'b1;
    w.start_position = 32'd0;
    send_batch_byte(w);
    w.in_byte        = 8'h55;
    w.batch_last     = 1'b0;
    send_batch_byte(w);
    n_batches++;
  endtask

  task automatic test_value_bytes();
    run_phase(1'b0, 32'd0, 2);
  endtask

  task automatic test_pointer_mode();
    run_phase(1'b1, 32'hFFFF_FFFF, 2);
    run_phase(1'b1, $urandom(), 2);
  endtask

  task automatic test_unpaced_stream();
    pace_on = 1'b0;
    wait_drained();
    run_phase(1'b0, $urandom(), 2);
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_implicit_start();
    test_one_byte_batch();
    test_value_bytes();
    test_pointer_mode();
    test_unpaced_stream();
    in_valid <= 1'b0;
    @(posedge clk);
    while (parsed_words_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (parsed_words_q.size() != 0)
      report_mismatch($sformatf("%0d words never came", parsed_words_q.size()));
    $display("Sent %0d bytes in %0d batches, checked %0d result words", n_in_words,
             n_batches, n_out_words);
    $display("Covered every status, padded lengths, pointer mode on and off, %0d errors",
             errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
